[rtl/smpc_pkg.sv]
`timescale 1ns / 1ps

package smpc_pkg;

    // Input transaction kinds
    localparam logic [1:0] KIND_EDGE_A  = 2'd0;
    localparam logic [1:0] KIND_EDGE_B  = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;
    localparam logic [1:0] KIND_COMMAND = 2'd3;

    // ASCII command codes
    localparam logic [7:0] CMD_SPEED     = 8'h73;  // s
    localparam logic [7:0] CMD_SET_HOME  = 8'h48;  // H
    localparam logic [7:0] CMD_SET_LEFT  = 8'h4C;  // L
    localparam logic [7:0] CMD_SET_RIGHT = 8'h52;  // R
    localparam logic [7:0] CMD_GO_HOME   = 8'h68;  // h
    localparam logic [7:0] CMD_GO_LEFT   = 8'h6C;  // l
    localparam logic [7:0] CMD_GO_RIGHT  = 8'h72;  // r

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 13;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEADZONE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_LIMIT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_SPEED  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_MIN   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_MAX   = 3'd4;

    localparam logic [11:0] DEADZONE_RST    = 12'd100;
    localparam logic [11:0] ERROR_LIMIT_RST = 12'd500;
    localparam logic [12:0] STOP_SPEED_RST  = 13'd3000;
    localparam logic [12:0] SPEED_MIN_RST   = 13'd2500;
    localparam logic [12:0] SPEED_MAX_RST   = 13'd3500;

    localparam logic [31:0] LEFT_BOUND_RST  = 32'hFFFE_7960;  // -100000
    localparam logic [31:0] RIGHT_BOUND_RST = 32'h0001_86A0;  //  100000

    localparam logic [12:0] MANUAL_BASE = 13'd1100;
    localparam logic [12:0] MANUAL_STEP = 13'd15;

    typedef struct packed {
        logic [1:0] kind;
        logic       edge_level;
        logic [7:0] command_code;
        logic [7:0] command_data;
    } in_item_t;

    typedef struct packed {
        logic [12:0]        motor_speed;
        logic signed [31:0] position_now;
        logic               feedback_mode;
    } out_item_t;

    typedef struct packed {
        logic [11:0] deadzone;
        logic [11:0] error_limit;
        logic [12:0] stop_speed;
        logic [12:0] speed_min;
        logic [12:0] speed_max;
    } cfg_regs_t;

    typedef struct packed {
        logic [31:0] position_count;
        logic        level_b;
        logic        mode_feedback;
        logic [31:0] target_position;
        logic [31:0] home_position;
        logic [31:0] left_bound;
        logic [31:0] right_bound;
        logic [12:0] speed_now;
    } ctrl_state_t;

    // When the limits cross, values below the low limit give the low limit and all others the high limit.
    function automatic logic [12:0] clamp_speed(input logic signed [14:0] s,
                                                input logic [12:0] lo,
                                                input logic [12:0] hi);
        logic [12:0] r;
        priority if (s < $signed({2'b00, lo}))
            r = lo;
        else if (s > $signed({2'b00, hi}))
            r = hi;
        else
            r = s[12:0];
        return r;
    endfunction

endpackage

[rtl/slide_motor_position_controller_top.sv]
// Slide motor position controller. Each input transaction (encoder A or B edge,
// control tick, or command byte) yields exactly one result transaction carrying
// the motor pulse width, the encoder position and the mode after that item. The
// block takes one item per clock cycle while the result channel accepts; an accepted
// input passes the input register, then the state update into the result register.
// Back-pressure on the result channel stalls the input register and then the input
// channel. Configuration writes (index 0..4: deadzone, error limit, stop speed,
// speed min, speed max; other indexes ignored) are always ready and must only be
// issued while no item is in flight.
`timescale 1ns / 1ps

module slide_motor_position_controller_top
    import smpc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    cfg_regs_t   cfg_reg;
    logic        out_load;
    logic        advance;

    assign out_load  = !out_valid_reg || out_ready;
    assign advance   = in_valid_reg && out_load;
    assign in_ready  = !in_valid_reg || out_load;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    smpc_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .item       (in_item_reg),
        .state_next (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (out_load)
                out_valid_reg <= in_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_item;
        if (advance)
        begin
            out_item_reg.motor_speed   <= state_next.speed_now;
            out_item_reg.position_now  <= $signed(state_next.position_count);
            out_item_reg.feedback_mode <= state_next.mode_feedback;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.position_count  <= 32'd0;
            state_reg.level_b         <= 1'b0;
            state_reg.mode_feedback   <= 1'b0;
            state_reg.target_position <= 32'd0;
            state_reg.home_position   <= 32'd0;
            state_reg.left_bound      <= LEFT_BOUND_RST;
            state_reg.right_bound     <= RIGHT_BOUND_RST;
            state_reg.speed_now       <= STOP_SPEED_RST;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadzone    <= DEADZONE_RST;
            cfg_reg.error_limit <= ERROR_LIMIT_RST;
            cfg_reg.stop_speed  <= STOP_SPEED_RST;
            cfg_reg.speed_min   <= SPEED_MIN_RST;
            cfg_reg.speed_max   <= SPEED_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DEADZONE:    cfg_reg.deadzone    <= cfg_data[11:0];
                CFG_ERROR_LIMIT: cfg_reg.error_limit <= cfg_data[11:0];
                CFG_STOP_SPEED:  cfg_reg.stop_speed  <= cfg_data;
                CFG_SPEED_MIN:   cfg_reg.speed_min   <= cfg_data;
                CFG_SPEED_MAX:   cfg_reg.speed_max   <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

[rtl/smpc_step.sv]
`timescale 1ns / 1ps

module smpc_step
    import smpc_pkg::*;
(
    input  ctrl_state_t state,
    input  cfg_regs_t   cfg,
    input  in_item_t    item,
    output ctrl_state_t state_next
);

    logic signed [31:0] diff;
    logic signed [31:0] lim32;
    logic signed [12:0] err;
    logic signed [13:0] err_w;
    logic signed [13:0] dz_w;
    logic               outside_dz;
    logic signed [14:0] fb_raw;
    logic [12:0]        stop_c;
    logic [12:0]        spd_fb;
    logic [12:0]        spd_left;
    logic [12:0]        spd_tick;
    logic [12:0]        manual_raw;
    logic               below_left;
    logic               above_right;

    // Feedback path: clamp error, apply deadzone, clamp speed
    always_comb
    begin
        diff  = $signed(state.position_count - state.target_position);
        lim32 = $signed({20'd0, cfg.error_limit});
        priority if (diff > lim32)
            err = $signed({1'b0, cfg.error_limit});
        else if (diff < -lim32)
            err = -$signed({1'b0, cfg.error_limit});
        else
            err = diff[12:0];

        err_w      = {err[12], err};
        dz_w       = $signed({2'b00, cfg.deadzone});
        outside_dz = (err_w > dz_w) || (err_w < -dz_w);
        fb_raw     = $signed({2'b00, cfg.stop_speed}) - $signed({{2{err[12]}}, err});
        stop_c     = clamp_speed($signed({2'b00, cfg.stop_speed}), cfg.speed_min,
                                 cfg.speed_max);

        if (!state.mode_feedback)
            spd_fb = state.speed_now;
        else if (outside_dz)
            spd_fb = clamp_speed(fb_raw, cfg.speed_min, cfg.speed_max);
        else
            spd_fb = stop_c;

        // Bound stops see the speed left by the previous check
        below_left  = $signed(state.position_count) < $signed(state.left_bound);
        above_right = $signed(state.position_count) > $signed(state.right_bound);
        spd_left = (below_left && (spd_fb < cfg.stop_speed)) ? stop_c : spd_fb;
        spd_tick = (above_right && (spd_left > cfg.stop_speed)) ? stop_c : spd_left;

        manual_raw = item.command_data * MANUAL_STEP + MANUAL_BASE;
    end

    always_comb
    begin
        state_next = state;
        unique case (item.kind)
            KIND_EDGE_A:
            begin
                if (item.edge_level)
                begin
                    if (!state.level_b)
                        state_next.position_count = state.position_count + 32'd1;
                    else
                        state_next.position_count = state.position_count - 32'd1;
                end
            end
            KIND_EDGE_B:
                state_next.level_b = item.edge_level;
            KIND_TICK:
                state_next.speed_now = spd_tick;
            KIND_COMMAND:
            begin
                unique case (item.command_code)
                    CMD_SPEED:
                    begin
                        state_next.mode_feedback = 1'b0;
                        state_next.speed_now = clamp_speed($signed({2'b00, manual_raw}),
                                                           cfg.speed_min, cfg.speed_max);
                    end
                    CMD_SET_HOME:  state_next.home_position = state.position_count;
                    CMD_SET_LEFT:  state_next.left_bound = state.position_count;
                    CMD_SET_RIGHT: state_next.right_bound = state.position_count;
                    CMD_GO_HOME:
                    begin
                        state_next.mode_feedback   = 1'b1;
                        state_next.target_position = state.home_position;
                    end
                    CMD_GO_LEFT:
                    begin
                        state_next.mode_feedback   = 1'b1;
                        state_next.target_position = state.left_bound;
                    end
                    CMD_GO_RIGHT:
                    begin
                        state_next.mode_feedback   = 1'b1;
                        state_next.target_position = state.right_bound;
                    end
                    default: ;
                endcase
            end
        endcase
    end

endmodule

[rtl/smpc_checker.sv]
`timescale 1ns / 1ps

module smpc_checker
    import smpc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    logic [1:0]         pending_reg;
    logic [1:0]         pending_next;
    logic signed [31:0] last_pos_reg;
    logic               have_last_reg;
    logic               in_fire;
    logic               out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_fire && !out_fire)
            pending_next = pending_reg + 2'd1;
        else if (!in_fire && out_fire)
            pending_next = pending_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 2'd0;
            have_last_reg <= 1'b0;
            last_pos_reg  <= 32'sd0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (out_fire)
            begin
                have_last_reg <= 1'b1;
                last_pos_reg  <= out_item.position_now;
            end
        end
    end

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // No result without an outstanding input transaction
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result without accepted input");

    // At most two transactions in flight
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("too many transactions in flight");

    // Input is never blocked while the result side is empty
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result stage");

    // Position moves by at most one count between results
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && have_last_reg |->
            (out_item.position_now == last_pos_reg) ||
            (out_item.position_now == last_pos_reg + 32'sd1) ||
            (out_item.position_now == last_pos_reg - 32'sd1))
        else $error("position jumped by more than one count");

endmodule

bind slide_motor_position_controller_top smpc_checker u_smpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
    import smpc_pkg::*;

    localparam int unsigned ITEMS_PER_SEGMENT = 130;
    localparam int unsigned SEGMENTS = 6;
    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam longint SPEED_STEP = 15;
    localparam longint SPEED_BASE = 1100;

    typedef struct {
        in_item_t  stim;
        logic      typed;
        out_item_t want;
    } dir_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Controller model state and limits
    logic [31:0] enc_pos = '0;
    logic        enc_b_level = 1'b0;
    logic        fb_mode = 1'b0;
    logic [31:0] setpoint = '0;
    logic [31:0] home_pos = '0;
    logic [31:0] left_pos = LEFT_BOUND_RST;
    logic [31:0] right_pos = RIGHT_BOUND_RST;
    logic [12:0] drive_speed = STOP_SPEED_RST;
    logic [11:0] lim_deadzone = DEADZONE_RST;
    logic [11:0] lim_error = ERROR_LIMIT_RST;
    logic [12:0] lim_stop = STOP_SPEED_RST;
    logic [12:0] lim_min = SPEED_MIN_RST;
    logic [12:0] lim_max = SPEED_MAX_RST;

    out_item_t   expected_results[$];
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned quiet_cycles = 0;
    int unsigned send_idle_pct = 23;
    int unsigned recv_idle_pct = 72;

    slide_motor_position_controller_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    task automatic flag_mismatch(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic [12:0] fit_speed(input longint s);
        logic [12:0] r;
        if (s < longint'(lim_min))
            r = lim_min;
        else if (s > longint'(lim_max))
            r = lim_max;
        else
            r = s[12:0];
        return r;
    endfunction

    function automatic out_item_t step_controller(input in_item_t it);
        out_item_t res;
        logic signed [31:0] diff;
        logic signed [31:0] pos_s;
        logic signed [31:0] left_s;
        logic signed [31:0] right_s;
        longint err;
        longint lim;
        longint dz;
        case (it.kind)
            KIND_EDGE_A:
            begin
                if (it.edge_level)
                    enc_pos = enc_b_level ? enc_pos - 32'd1 : enc_pos + 32'd1;
            end
            KIND_EDGE_B:
            begin
                enc_b_level = it.edge_level;
            end
            KIND_TICK:
            begin
                if (fb_mode)
                begin
                    diff = enc_pos - setpoint;
                    err = longint'(diff);
                    lim = longint'(lim_error);
                    dz = longint'(lim_deadzone);
                    if (err > lim)
                        err = lim;
                    if (err < -lim)
                        err = -lim;
                    if (err > dz || err < -dz)
                        drive_speed = fit_speed(longint'(lim_stop) - err);
                    else
                        drive_speed = fit_speed(longint'(lim_stop));
                end
                // stop when past a bound and still heading outward; left first
                pos_s = enc_pos;
                left_s = left_pos;
                right_s = right_pos;
                if (pos_s < left_s && drive_speed < lim_stop)
                    drive_speed = fit_speed(longint'(lim_stop));
                if (pos_s > right_s && drive_speed > lim_stop)
                    drive_speed = fit_speed(longint'(lim_stop));
            end
            KIND_COMMAND:
            begin
                case (it.command_code)
                    CMD_SPEED:
                    begin
                        fb_mode = 1'b0;
                        drive_speed = fit_speed(longint'(it.command_data) * SPEED_STEP
                                                + SPEED_BASE);
                    end
                    CMD_SET_HOME:  home_pos = enc_pos;
                    CMD_SET_LEFT:  left_pos = enc_pos;
                    CMD_SET_RIGHT: right_pos = enc_pos;
                    CMD_GO_HOME:
                    begin
                        fb_mode = 1'b1;
                        setpoint = home_pos;
                    end
                    CMD_GO_LEFT:
                    begin
                        fb_mode = 1'b1;
                        setpoint = left_pos;
                    end
                    CMD_GO_RIGHT:
                    begin
                        fb_mode = 1'b1;
                        setpoint = right_pos;
                    end
                    default: ;
                endcase
            end
        endcase
        res.motor_speed = drive_speed;
        res.position_now = enc_pos;
        res.feedback_mode = fb_mode;
        return res;
    endfunction

    // Hold valid and payload until accepted; valid stays high for the next call.
    task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
        out_item_t pred;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (!in_ready);
        pred = step_controller(it);
        expected_results.push_back(typed ? want : pred);
        items_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_DEADZONE:    lim_deadzone = val[11:0];
            CFG_ERROR_LIMIT: lim_error = val[11:0];
            CFG_STOP_SPEED:  lim_stop = val;
            CFG_SPEED_MIN:   lim_min = val;
            CFG_SPEED_MAX:   lim_max = val;
            default: ;
        endcase
    endtask

    task automatic program_limits(input int unsigned dz, input int unsigned el,
                                  input int unsigned stop, input int unsigned lo,
                                  input int unsigned hi);
        logic [31:0] r;
        logic [CFG_INDEX_W-1:0] spare;
        drain_results();
        r = $urandom;
        write_reg(CFG_DEADZONE, dz[CFG_DATA_W-1:0]);
        write_reg(CFG_ERROR_LIMIT, el[CFG_DATA_W-1:0]);
        write_reg(CFG_STOP_SPEED, stop[CFG_DATA_W-1:0]);
        write_reg(CFG_SPEED_MIN, lo[CFG_DATA_W-1:0]);
        // an index past the last register must change nothing
        spare = CFG_SPEED_MAX + {1'b0, r[1:0] | 2'b01};
        write_reg(spare, r[CFG_DATA_W+1:2]);
        write_reg(CFG_SPEED_MAX, hi[CFG_DATA_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_sequence();
        in_item_t    it;
        logic [31:0] r;
        int unsigned pick;
        int unsigned reps;
        pick = $urandom_range(0, 99);
        r = $urandom;
        it = r[$bits(in_item_t)-1:0];
        if (pick < 40)
        begin
            // pick a direction, then run a burst of encoder counts
            it.kind = KIND_EDGE_B;
            send_item(it, 1'b0, '0);
            reps = $urandom_range(1, 60);
            repeat (reps)
            begin
                r = $urandom;
                it = r[$bits(in_item_t)-1:0];
                it.kind = KIND_EDGE_A;
                it.edge_level = 1'b1;
                send_item(it, 1'b0, '0);
                if ($urandom_range(0, 3) == 0)
                begin
                    it.edge_level = 1'b0;
                    send_item(it, 1'b0, '0);
                end
            end
        end
        else if (pick < 65)
        begin
            reps = $urandom_range(1, 4);
            repeat (reps)
            begin
                r = $urandom;
                it = r[$bits(in_item_t)-1:0];
                it.kind = KIND_TICK;
                send_item(it, 1'b0, '0);
            end
        end
        else if (pick < 93)
        begin
            it.kind = KIND_COMMAND;
            case ($urandom_range(0, 6))
                0: it.command_code = CMD_SPEED;
                1: it.command_code = CMD_SET_HOME;
                2: it.command_code = CMD_SET_LEFT;
                3: it.command_code = CMD_SET_RIGHT;
                4: it.command_code = CMD_GO_HOME;
                5: it.command_code = CMD_GO_LEFT;
                default: it.command_code = CMD_GO_RIGHT;
            endcase
            send_item(it, 1'b0, '0);
            it.kind = KIND_TICK;
            send_item(it, 1'b0, '0);
        end
        else
        begin
            send_item(it, 1'b0, '0);
        end
        if ($urandom_range(0, 199) == 0)
            drain_results();
    endtask

    function automatic dir_row_t mk_row(input logic [1:0] k, input logic lvl,
                                        input logic [7:0] code, input logic [7:0] data,
                                        input logic typed, input logic [12:0] spd,
                                        input logic signed [31:0] pos, input logic fb);
        dir_row_t row;
        row.stim.kind = k;
        row.stim.edge_level = lvl;
        row.stim.command_code = code;
        row.stim.command_data = data;
        row.typed = typed;
        row.want.motor_speed = spd;
        row.want.position_now = pos;
        row.want.feedback_mode = fb;
        return row;
    endfunction

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                flag_mismatch("result transaction with nothing expected");
            else
            begin
                want = expected_results.pop_front();
                if (out_item.motor_speed !== want.motor_speed)
                    flag_mismatch($sformatf("motor_speed got %0d want %0d",
                                            out_item.motor_speed, want.motor_speed));
                if (out_item.position_now !== want.position_now)
                    flag_mismatch($sformatf("position_now got %0d want %0d",
                                            out_item.position_now, want.position_now));
                if (out_item.feedback_mode !== want.feedback_mode)
                    flag_mismatch($sformatf("feedback_mode got %0b want %0b",
                                            out_item.feedback_mode, want.feedback_mode));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        dir_row_t    directed[$];
        int unsigned seg;
        int unsigned seg_base;

        directed.push_back(mk_row(KIND_TICK, 1'b0, 8'h00, 8'h00, 1'b1, 13'd3000, 32'sd0, 1'b0));
        directed.push_back(mk_row(KIND_EDGE_A, 1'b1, 8'h00, 8'h00, 1'b1, 13'd3000, 32'sd1, 1'b0));
        directed.push_back(mk_row(KIND_EDGE_A, 1'b0, 8'h00, 8'h00, 1'b1, 13'd3000, 32'sd1, 1'b0));
        directed.push_back(mk_row(KIND_EDGE_B, 1'b1, 8'h00, 8'h00, 1'b1, 13'd3000, 32'sd1, 1'b0));
        directed.push_back(mk_row(KIND_EDGE_A, 1'b1, 8'h00, 8'h00, 1'b1, 13'd3000, 32'sd0, 1'b0));
        directed.push_back(mk_row(KIND_EDGE_A, 1'b1, 8'h00, 8'h00, 1'b1, 13'd3000, -32'sd1, 1'b0));
        directed.push_back(mk_row(KIND_COMMAND, 1'b0, CMD_SPEED, 8'h00, 1'b1, 13'd2500, -32'sd1,
                                  1'b0));
        directed.push_back(mk_row(KIND_COMMAND, 1'b1, CMD_SPEED, 8'hFF, 1'b1, 13'd3500, -32'sd1,
                                  1'b0));
        directed.push_back(mk_row(KIND_COMMAND, 1'b0, CMD_SET_HOME, 8'h00, 1'b0, '0, '0, 1'b0));
        directed.push_back(mk_row(KIND_COMMAND, 1'b0, 8'h00, 8'h00, 1'b0, '0, '0, 1'b0));
        directed.push_back(mk_row(KIND_COMMAND, 1'b1, 8'hFF, 8'hFF, 1'b0, '0, '0, 1'b0));
        directed.push_back(mk_row(KIND_COMMAND, 1'b0, CMD_SET_LEFT, 8'h00, 1'b0, '0, '0, 1'b0));
        directed.push_back(mk_row(KIND_COMMAND, 1'b0, CMD_SET_RIGHT, 8'h00, 1'b0, '0, '0, 1'b0));
        directed.push_back(mk_row(KIND_EDGE_B, 1'b0, 8'hFF, 8'hFF, 1'b0, '0, '0, 1'b0));
        directed.push_back(mk_row(KIND_EDGE_A, 1'b1, 8'hFF, 8'hFF, 1'b0, '0, '0, 1'b0));
        // past the right bound while driving outward
        directed.push_back(mk_row(KIND_TICK, 1'b1, 8'hFF, 8'hFF, 1'b0, '0, '0, 1'b0));
        directed.push_back(mk_row(KIND_COMMAND, 1'b0, CMD_GO_HOME, 8'h00, 1'b0, '0, '0, 1'b0));
        directed.push_back(mk_row(KIND_TICK, 1'b0, 8'h00, 8'h00, 1'b0, '0, '0, 1'b0));
        directed.push_back(mk_row(KIND_COMMAND, 1'b0, CMD_GO_LEFT, 8'h00, 1'b0, '0, '0, 1'b0));
        directed.push_back(mk_row(KIND_COMMAND, 1'b0, CMD_GO_RIGHT, 8'h00, 1'b0, '0, '0, 1'b0));
        directed.push_back(mk_row(KIND_EDGE_B, 1'b1, 8'h00, 8'h00, 1'b0, '0, '0, 1'b0));
        directed.push_back(mk_row(KIND_EDGE_A, 1'b1, 8'h00, 8'h00, 1'b0, '0, '0, 1'b0));
        directed.push_back(mk_row(KIND_EDGE_A, 1'b1, 8'h00, 8'h00, 1'b0, '0, '0, 1'b0));
        directed.push_back(mk_row(KIND_COMMAND, 1'b0, CMD_SPEED, 8'h00, 1'b0, '0, '0, 1'b0));
        // past the left bound while driving outward
        directed.push_back(mk_row(KIND_TICK, 1'b0, 8'h00, 8'h00, 1'b0, '0, '0, 1'b0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_item(directed[i].stim, directed[i].typed, directed[i].want);

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            send_idle_pct = (seg < 2) ? 23 : (seg < 4) ? 72 : 0;
            recv_idle_pct = (seg < 2) ? 72 : (seg < 4) ? 23 : 0;
            case (seg)
                0: program_limits(20, 300, 3000, 2000, 4000);
                1: program_limits(0, 4095, 8191, 0, 8191);
                2: program_limits(5, 50, 3000, 3200, 2800);     // crossed limits
                3: program_limits(8191, 4096, 0, 0, 0);         // bit 12 dropped on 12-bit regs
                4: program_limits($urandom_range(0, 200), $urandom_range(0, 4095),
                                  $urandom_range(0, 8191), $urandom_range(0, 4000),
                                  $urandom_range(2000, 8191));
                default: program_limits(10, 4095, 100, 0, 8191); // speed can go negative
            endcase
            seg_base = items_sent;
            while (items_sent - seg_base < ITEMS_PER_SEGMENT)
                send_random_sequence();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
